// ===== sv/deq_pkg.sv =====
// Shared constants for the double-ended queue: field widths, default depth, action and status codes.
package deq_pkg;

  // Field widths of the transaction ports
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 7;

  // Default number of entries
  localparam int DEPTH_DEF = 64;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR      = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_DUMP       = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ===== sv/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values held in a ring buffer RAM.
//
//  channel   | signals                                 | handshake
//  ----------+-----------------------------------------+-------------------------------
//  command   | action, value_in                        | taken when start && !busy
//  result    | value_out, status, fill_level, last     | valid while done is high
//
//  Push, clear, unused codes and a pop or dump of an empty queue are answered directly; the
//  result appears the cycle after the command and the next command may follow.
//  A pop of a non-empty queue passes through ST_POP to wait for the RAM's registered read data.
//  A dump reads the RAM once per element and streams the elements out, one per result.
//  Reset (rst, synchronous) empties the queue at once; there is no clearing pass.
//  Results cannot be stalled; each is valid for exactly the cycle done is high.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic        [deq_pkg::ACTION_W-1:0] action,
  input  logic signed [deq_pkg::VALUE_W-1:0]  value_in,
  output logic                                done,
  output logic signed [deq_pkg::VALUE_W-1:0]  value_out,
  output logic        [deq_pkg::STATUS_W-1:0] status,
  output logic        [deq_pkg::FILL_W-1:0]   fill_level,
  output logic                                last
);

  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_DUMP
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   front;
  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   dump_pos;
  logic [CNT_W-1:0]   dump_left;

  logic [SUM_W-1:0]   tail_sum;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   back_pos;
  logic [IDX_W-1:0]   front_inc;
  logic [IDX_W-1:0]   front_dec;
  logic [IDX_W-1:0]   dump_inc;
  logic               full;
  logic               empty;
  logic               accept;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  logic [VALUE_W-1:0] rd_data;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  // Ring pointer arithmetic, wrapped at DEPTH
  always_comb begin
    tail_sum  = SUM_W'(front) + SUM_W'(count);
    tail      = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                            : IDX_W'(tail_sum);
    back_pos  = (tail == '0) ? IDX_W'(DEPTH - 1) : tail - IDX_W'(1);
    front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + IDX_W'(1);
    front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - IDX_W'(1);
    dump_inc  = (dump_pos == IDX_W'(DEPTH - 1)) ? '0 : dump_pos + IDX_W'(1);
  end

  // RAM access: pushes write at accept, pops and dumps read ahead
  always_comb begin
    wr_en   = accept && !full &&
              ((action == ACT_PUSH_FRONT) || (action == ACT_PUSH_BACK));
    wr_addr = (action == ACT_PUSH_FRONT) ? front_dec : tail;
    if (state == ST_DUMP) begin
      rd_addr = dump_inc;
    end else if (action == ACT_POP_BACK) begin
      rd_addr = back_pos;
    end else begin
      rd_addr = front;
    end
  end

  deq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (VALUE_W'(value_in)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: pointers, count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      front <= '0;
      count <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            value_out  <= '0;
            status     <= STAT_OK;
            fill_level <= FILL_W'(count);
            last       <= 1'b1;
            unique case (action)
              ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                done <= 1'b1;
                if (full) begin
                  status <= STAT_FULL;
                end else begin
                  if (action == ACT_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                  count      <= count + CNT_W'(1);
                  fill_level <= FILL_W'(count + CNT_W'(1));
                end
              end
              ACT_POP_FRONT, ACT_POP_BACK: begin
                if (empty) begin
                  done   <= 1'b1;
                  status <= STAT_EMPTY;
                end else begin
                  if (action == ACT_POP_FRONT) begin
                    front <= front_inc;
                  end
                  count <= count - CNT_W'(1);
                  state <= ST_POP;
                end
              end
              ACT_CLEAR: begin
                done       <= 1'b1;
                count      <= '0;
                fill_level <= '0;
              end
              ACT_DUMP: begin
                if (empty) begin
                  done   <= 1'b1;
                  status <= STAT_EMPTY;
                end else begin
                  dump_pos  <= front;
                  dump_left <= count;
                  state     <= ST_DUMP;
                end
              end
              default: begin
                // unused codes: plain ok result, queue untouched
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_POP: begin
          // read data of the popped entry is ready now
          done       <= 1'b1;
          value_out  <= signed'(rd_data);
          status     <= STAT_OK;
          fill_level <= FILL_W'(count);
          last       <= 1'b1;
          state      <= ST_IDLE;
        end
        ST_DUMP: begin
          // stream one element per cycle, next read already issued
          done       <= 1'b1;
          value_out  <= signed'(rd_data);
          status     <= STAT_OK;
          fill_level <= FILL_W'(count);
          last       <= (dump_left == CNT_W'(1));
          dump_pos   <= dump_inc;
          dump_left  <= dump_left - CNT_W'(1);
          if (dump_left == CNT_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/double_ended_queue_tb.sv =====
// Self-checking testbench for the double-ended queue: predictor scoreboard, stimulus and monitor.
`timescale 1ns / 100ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 60;
  localparam int QUIET_ITEMS  = 15;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int TAIL_CYCLES  = DEPTH + 8;

  // Codes the block treats as no-ops
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
    logic [FILL_W-1:0]         fill;
    logic                      last;
  } deque_result_t;

  // Scoreboard: tracks deque contents and the results each transaction should produce
  class deque_tracker;
    logic signed [VALUE_W-1:0] cells [DEPTH];
    int                        front;
    int                        count;
    deque_result_t             expected_q [$];
    int                        mismatches;

    function new();
      front      = 0;
      count      = 0;
      mismatches = 0;
    endfunction

    function void add_result(logic signed [VALUE_W-1:0] v, logic [STATUS_W-1:0] st,
                             logic lst);
      deque_result_t r;
      r.value  = v;
      r.status = st;
      r.fill   = count[FILL_W-1:0];
      r.last   = lst;
      expected_q.push_back(r);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH @%0t: %s", $time, msg);
    endfunction

    // Apply one accepted transaction to the model state
    function void note_command(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] val);
      logic signed [VALUE_W-1:0] v;
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (count >= DEPTH) begin
            add_result('0, STAT_FULL, 1'b1);
          end else begin
            if (act == ACT_PUSH_FRONT) begin
              front        = (front + DEPTH - 1) % DEPTH;
              cells[front] = val;
            end else begin
              cells[(front + count) % DEPTH] = val;
            end
            count++;
            add_result('0, STAT_OK, 1'b1);
          end
        end
        ACT_POP_FRONT, ACT_POP_BACK: begin
          if (count == 0) begin
            add_result('0, STAT_EMPTY, 1'b1);
          end else begin
            if (act == ACT_POP_FRONT) begin
              v     = cells[front];
              front = (front + 1) % DEPTH;
            end else begin
              v = cells[(front + count - 1) % DEPTH];
            end
            count--;
            add_result(v, STAT_OK, 1'b1);
          end
        end
        ACT_CLEAR: begin
          count = 0;
          add_result('0, STAT_OK, 1'b1);
        end
        ACT_DUMP: begin
          if (count == 0) add_result('0, STAT_EMPTY, 1'b1);
          else for (int i = 0; i < count; i++)
            add_result(cells[(front + i) % DEPTH], STAT_OK, i == count - 1);
        end
        default: add_result('0, STAT_OK, 1'b1);
      endcase
    endfunction

    // Compare one observed result against the oldest expectation
    function void check_result(logic signed [VALUE_W-1:0] v, logic [STATUS_W-1:0] st,
                               logic [FILL_W-1:0] fl, logic lst);
      deque_result_t e;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected result value=%0d status=%0d fill=%0d last=%0b",
                       v, st, fl, lst));
      end else begin
        e = expected_q.pop_front();
        if (e.value !== v || e.status !== st || e.fill !== fl || e.last !== lst)
          flag($sformatf({"expected value=%0d status=%0d fill=%0d last=%0b, ",
                          "got value=%0d status=%0d fill=%0d last=%0b"},
                         e.value, e.status, e.fill, e.last, v, st, fl, lst));
      end
    endfunction
  endclass

  logic                       clk      = 1'b0;
  logic                       rst      = 1'b1;
  logic                       start    = 1'b0;
  logic [ACTION_W-1:0]        action   = ACT_CLEAR;
  logic signed [VALUE_W-1:0]  value_in = '0;
  logic                       busy;
  logic                       done;
  logic signed [VALUE_W-1:0]  value_out;
  logic [STATUS_W-1:0]        status;
  logic [FILL_W-1:0]          fill_level;
  logic                       last;
  int                         cycles = 0;
  deque_tracker               tracker = new();

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .value_in   (value_in),
    .done       (done),
    .value_out  (value_out),
    .status     (status),
    .fill_level (fill_level),
    .last       (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Result monitor: every strobed result is checked at the edge that ends it
  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(value_out, status, fill_level, last);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it
  task automatic issue(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] val);
    start    <= 1'b1;
    action   <= act;
    value_in <= val;
    do @(posedge clk); while (busy);
    tracker.note_command(act, val);
  endtask

  // Sender gap, taken now and then: start is dropped and the sender idles
  task automatic maybe_gap(bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [ACTION_W-1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 28)      return ACT_PUSH_FRONT;
    else if (r < 56) return ACT_PUSH_BACK;
    else if (r < 72) return ACT_POP_FRONT;
    else if (r < 88) return ACT_POP_BACK;
    else if (r < 91) return ACT_CLEAR;
    else if (r < 97) return ACT_DUMP;
    else if (r < 98) return ACT_SPARE_A;
    else             return ACT_SPARE_B;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty cases, value extremes, every action code
    issue(ACT_POP_FRONT, 32'sd0);
    issue(ACT_POP_BACK, -32'sd1);
    issue(ACT_DUMP, 32'sd0);
    issue(ACT_PUSH_FRONT, 32'sh80000000);
    issue(ACT_PUSH_BACK, 32'sh7fffffff);
    issue(ACT_PUSH_BACK, -32'sd1);
    issue(ACT_PUSH_FRONT, 32'sd0);
    issue(ACT_DUMP, 32'sh55555555);
    issue(ACT_POP_FRONT, 32'sh12345678);
    issue(ACT_POP_BACK, 32'sd0);
    issue(ACT_SPARE_A, 32'sh7fffffff);
    issue(ACT_SPARE_B, 32'sh80000000);
    issue(ACT_DUMP, 32'sd0);
    issue(ACT_CLEAR, -32'sd1);
    issue(ACT_DUMP, 32'sd0);
    issue(ACT_POP_BACK, 32'sd0);

    // Fill to capacity from both ends, overflow, dump the full queue
    while (tracker.count < DEPTH) begin
      issue($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, $urandom);
      maybe_gap(1'b1);
    end
    issue(ACT_PUSH_FRONT, $urandom);
    issue(ACT_PUSH_BACK, $urandom);
    issue(ACT_DUMP, $urandom);

    // Hold off until the full dump has drained out
    start <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat ($urandom_range(1, 4)) @(posedge clk);

    // Drain from both ends, then underflow
    while (tracker.count > 0) begin
      issue($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK, $urandom);
      maybe_gap(1'b1);
    end
    issue(ACT_POP_FRONT, $urandom);
    issue(ACT_DUMP, $urandom);

    // Random mix, biased toward pushes so the queue builds up and wraps
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      issue(pick_action(), $urandom);
      maybe_gap(n < RANDOM_ITEMS - QUIET_ITEMS);
    end
    issue(ACT_DUMP, $urandom);

    start <= 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule

// ===== double_ended_queue.f =====
sv/deq_pkg.sv
sv/deq_ram.sv
sv/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
